// ===== hdl/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants
// Widths, angle constants, the arctangent step table, the payload structs
// and the helper functions of the quaternion to Euler angle unit.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int QUAT_WIDTH = 16;
    localparam int CORE_W = (QUAT_WIDTH > 24) ? 24 : QUAT_WIDTH;
    localparam int DROP_W = QUAT_WIDTH - CORE_W;
    localparam int PROD_W = 2 * CORE_W;
    localparam int SUM_W = 2 * CORE_W + 2;
    localparam int MAG_W = (SUM_W > 32) ? SUM_W : 32;
    localparam int LEAD_W = $clog2(MAG_W);
    localparam int NORM_MSB = 29;
    localparam int NORM_W = 31;
    localparam int ROOT_W = 31;
    localparam int ROOT_SHIFT_MSB = 30;
    localparam int CORD_W = 34;
    localparam int ANGLE_W = 33;
    localparam int SQ_W = 63;
    localparam int SQRT_STEPS = 32;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_TAB_LEN = 24;
    localparam int DEG_K_W = 30;
    localparam int DEG_PROD_W = ANGLE_W + DEG_K_W;
    localparam int OUT_W = 16;
    localparam int RAD_LIMIT = 25736;
    localparam int DEG_LIMIT = 23040;
    localparam int FULL_TURN = 46080;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic [MAG_W-1:0] mag_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    localparam angle_t ANG_PI = 33'sd3373259426;
    localparam angle_t ANG_HALF_PI = 33'sd1686629713;
    localparam logic signed [DEG_K_W-1:0] DEG_K = 30'sd480631834;

    localparam angle_t ATAN_TAB [ATAN_TAB_LEN] = '{
        33'sh03243F6A8, 33'sh01DAC6705, 33'sh00FADBAFC, 33'sh007F56EA6,
        33'sh003FEAB76, 33'sh001FFD55B, 33'sh000FFFAAA, 33'sh0007FFF55,
        33'sh0003FFFEA, 33'sh0001FFFFD, 33'sh0000FFFFF, 33'sh00007FFFF,
        33'sh00003FFFF, 33'sh00001FFFF, 33'sh00000FFFF, 33'sh000007FFF,
        33'sh000003FFF, 33'sh000001FFF, 33'sh000000FFF, 33'sh0000007FF,
        33'sh0000003FF, 33'sh0000001FF, 33'sh0000000FF, 33'sh00000007F
    };

    typedef struct packed {
        logic signed [QUAT_WIDTH-1:0] q_real;
        logic signed [QUAT_WIDTH-1:0] q_i;
        logic signed [QUAT_WIDTH-1:0] q_j;
        logic signed [QUAT_WIDTH-1:0] q_k;
    } quat_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] yaw_angle;
        logic signed [OUT_W-1:0] pitch_angle;
        logic signed [OUT_W-1:0] roll_angle;
        logic [OUT_W-1:0]        heading_angle;
    } euler_t;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zero_x;
        logic zero_y;
    } atan_flags_t;

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        angle_t                   z;
    } cordic_t;

    function automatic mag_t magnitude(sum_t v);
        logic [SUM_W-1:0] raw;
        logic [SUM_W-1:0] u;
        raw = v;
        u = raw[SUM_W-1] ? (~raw + 1'b1) : raw;
        return MAG_W'(u);
    endfunction

    function automatic logic [LEAD_W-1:0] lead_one(mag_t v);
        logic [LEAD_W-1:0] p;
        p = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (v[i])
            begin
                p = LEAD_W'(i);
            end
        end
        return p;
    endfunction

endpackage

// ===== hdl/qte_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// qte_sqrt_cell: one step of the integer square root
// Tries one result bit against the remainder and hands remainder and
// partial root to the next cell.
// ----------------------------------------------------------------------------
module qte_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [qte_pkg::SQ_W-1:0]   v_in,
    input  logic [qte_pkg::SQ_W-1:0]   r_in,
    output logic [qte_pkg::SQ_W-1:0]   v_out,
    output logic [qte_pkg::SQ_W-1:0]   r_out
);

    localparam logic [qte_pkg::SQ_W-1:0] BIT_VAL =
        qte_pkg::SQ_W'(1) << (2 * (qte_pkg::SQRT_STEPS - 1 - STEP));

    logic [qte_pkg::SQ_W:0]   trial;
    logic [qte_pkg::SQ_W-1:0] v_next;
    logic [qte_pkg::SQ_W-1:0] r_next;
    logic [qte_pkg::SQ_W-1:0] v_reg;
    logic [qte_pkg::SQ_W-1:0] r_reg;

    always_comb
    begin
        trial = {1'b0, r_in} + {1'b0, BIT_VAL};
        if ({1'b0, v_in} >= trial)
        begin
            v_next = v_in - trial[qte_pkg::SQ_W-1:0];
            r_next = (r_in >> 1) + BIT_VAL;
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= v_next;
            r_reg <= r_next;
        end
    end

    assign v_out = v_reg;
    assign r_out = r_reg;

endmodule

// ===== hdl/qte_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// qte_cordic_cell: one vectoring micro-rotation
// Rotates the vector toward the x axis by the step angle of its stage.
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                 clk,
    input  logic                 en,
    input  qte_pkg::cordic_t     d_in,
    input  qte_pkg::atan_flags_t f_in,
    output qte_pkg::cordic_t     d_out,
    output qte_pkg::atan_flags_t f_out
);

    localparam qte_pkg::angle_t STEP_ANGLE = qte_pkg::ATAN_TAB[STAGE];

    logic signed [qte_pkg::CORD_W-1:0] dx;
    logic signed [qte_pkg::CORD_W-1:0] dy;
    qte_pkg::cordic_t                  d_next;
    qte_pkg::cordic_t                  d_reg;
    qte_pkg::atan_flags_t              f_reg;

    always_comb
    begin
        dx = d_in.x >>> STAGE;
        dy = d_in.y >>> STAGE;
        if (!d_in.y[qte_pkg::CORD_W-1] && (d_in.y != '0))
        begin
            d_next.x = d_in.x + dy;
            d_next.y = d_in.y - dx;
            d_next.z = d_in.z + STEP_ANGLE;
        end
        else
        begin
            d_next.x = d_in.x - dy;
            d_next.y = d_in.y + dx;
            d_next.z = d_in.z - STEP_ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
            f_reg <= f_in;
        end
    end

    assign d_out = d_reg;
    assign f_out = f_reg;

endmodule

// ===== hdl/qte_atan_unit.sv =====
// ----------------------------------------------------------------------------
// qte_atan_unit: pipelined four-quadrant arctangent
// Normalizes two magnitudes, runs them through a row of CORDIC cells and
// folds the angle into the quadrant given by the operand signs.
// ----------------------------------------------------------------------------
module qte_atan_unit #(
    parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic            clk,
    input  logic            en,
    input  qte_pkg::mag_t   ux,
    input  qte_pkg::mag_t   uy,
    input  logic            neg_x,
    input  logic            neg_y,
    output qte_pkg::angle_t angle
);

    qte_pkg::mag_t                    ux_reg;
    qte_pkg::mag_t                    uy_reg;
    logic [qte_pkg::LEAD_W-1:0]       lead_reg;
    qte_pkg::atan_flags_t             flags_reg;
    qte_pkg::atan_flags_t             flags_next;
    qte_pkg::mag_t                    sx;
    qte_pkg::mag_t                    sy;
    logic [qte_pkg::LEAD_W-1:0]       shift;
    qte_pkg::cordic_t                 chain_d [STAGES+1];
    qte_pkg::atan_flags_t             chain_f [STAGES+1];
    qte_pkg::cordic_t                 start_next;
    qte_pkg::cordic_t                 start_reg;
    qte_pkg::atan_flags_t             start_f_reg;
    qte_pkg::angle_t                  angle_next;
    qte_pkg::angle_t                  angle_reg;

    always_comb
    begin
        flags_next.neg_x  = neg_x;
        flags_next.neg_y  = neg_y;
        flags_next.zero_x = (ux == '0);
        flags_next.zero_y = (uy == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg    <= ux;
            uy_reg    <= uy;
            lead_reg  <= qte_pkg::lead_one(ux | uy);
            flags_reg <= flags_next;
        end
    end

    always_comb
    begin
        if (lead_reg > qte_pkg::LEAD_W'(qte_pkg::NORM_MSB))
        begin
            shift = lead_reg - qte_pkg::LEAD_W'(qte_pkg::NORM_MSB);
            sx = ux_reg >> shift;
            sy = uy_reg >> shift;
        end
        else
        begin
            shift = qte_pkg::LEAD_W'(qte_pkg::NORM_MSB) - lead_reg;
            sx = ux_reg << shift;
            sy = uy_reg << shift;
        end
        start_next.x = signed'(qte_pkg::CORD_W'(sx[qte_pkg::NORM_W-1:0]));
        start_next.y = signed'(qte_pkg::CORD_W'(sy[qte_pkg::NORM_W-1:0]));
        start_next.z = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            start_reg   <= start_next;
            start_f_reg <= flags_reg;
        end
    end

    assign chain_d[0] = start_reg;
    assign chain_f[0] = start_f_reg;

    for (genvar g = 0; g < STAGES; g++)
    begin : g_cell
        qte_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .clk   (clk),
            .en    (en),
            .d_in  (chain_d[g]),
            .f_in  (chain_f[g]),
            .d_out (chain_d[g+1]),
            .f_out (chain_f[g+1])
        );
    end

    always_comb
    begin
        if (chain_f[STAGES].zero_y)
        begin
            angle_next = '0;
        end
        else if (chain_f[STAGES].zero_x)
        begin
            angle_next = qte_pkg::ANG_HALF_PI;
        end
        else
        begin
            angle_next = chain_d[STAGES].z;
        end
        if (chain_f[STAGES].neg_x)
        begin
            angle_next = qte_pkg::ANG_PI - angle_next;
        end
        if (chain_f[STAGES].neg_y)
        begin
            angle_next = -angle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

// ===== hdl/quaternion_to_euler_heading_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_heading_unit: yaw, pitch, roll and heading
// Turns quaternions into Euler angles and a compass heading.
//
//   Channel   Signals                               Direction
//   quat      quat_valid, quat_stall, quat          in, one transfer per item
//   euler     euler_valid, euler_stall, euler       out, one transfer per item
//   cfg       cfg_write_enable, cfg_write_data      in, unit select
//
// One quaternion is taken per cycle while the output is not stalled. The
// pitch path runs through the 32 square root cells and the CORDIC row.
// Reset empties the pipeline and selects degrees.
// When a result waits at the output under stall, the whole pipeline holds
// and quat_stall is raised in the same cycle.
// ----------------------------------------------------------------------------
module quaternion_to_euler_heading_unit #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            quat_valid,
    output logic            quat_stall,
    input  qte_pkg::quat_t  quat,
    output logic            euler_valid,
    input  logic            euler_stall,
    output qte_pkg::euler_t euler,
    input  logic            cfg_write_enable,
    input  logic            cfg_write_data
);

    localparam int ATAN_LAT = CORDIC_STAGES + 3;
    localparam int PREP_LAT = 4;
    localparam int PITCH_DELAY = PREP_LAT + qte_pkg::SQRT_STEPS;
    localparam int DEPTH = 3 + PITCH_DELAY + ATAN_LAT + 2;
    localparam int CW = qte_pkg::CORE_W;
    localparam int PW = qte_pkg::PROD_W;
    localparam int RW = qte_pkg::ROOT_W;
    localparam int DPW = qte_pkg::DEG_PROD_W;

    typedef logic signed [CW-1:0] comp_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [DPW-1:0] dprod_t;

    typedef struct packed {
        logic [RW-1:0] un;
        logic          sat;
        logic          neg;
        logic          zero;
    } pitch_ctx_t;

    logic [DEPTH-1:0] valid_reg;
    logic             en;
    logic             deg_mode_reg;

    comp_t r_reg, i_reg, j_reg, k_reg;
    prod_t rr_reg, ii_reg, jj_reg, kk_reg, ij_reg, kr_reg, ik_reg, jr_reg, jk_reg, ir_reg;
    qte_pkg::sum_t yaw_y_reg, yaw_x_reg, roll_y_reg, roll_x_reg, pnum_reg, pden_reg;
    qte_pkg::sum_t yaw_y_next, yaw_x_next, roll_y_next, roll_x_next, pnum_next, pden_next;

    qte_pkg::mag_t                un3_reg, ud3_reg;
    logic                         neg3_reg, zero3_reg;
    logic [qte_pkg::LEAD_W-1:0]   shift3_reg;
    logic [qte_pkg::LEAD_W-1:0]   lead3;
    logic [qte_pkg::LEAD_W-1:0]   shift3_next;
    qte_pkg::mag_t                un_sh, ud_sh;
    logic [RW-1:0]                ud4_reg;
    pitch_ctx_t                   ctx4_next, ctx4_reg, ctx5_reg, ctx6_reg;
    logic [qte_pkg::SQ_W-1:0]     udsq_reg, unsq_reg, diff_reg;
    pitch_ctx_t                   ctx_dly_reg [qte_pkg::SQRT_STEPS];
    logic [qte_pkg::SQ_W-1:0]     sq_v [qte_pkg::SQRT_STEPS+1];
    logic [qte_pkg::SQ_W-1:0]     sq_r [qte_pkg::SQRT_STEPS+1];

    pitch_ctx_t                   pctx;
    qte_pkg::mag_t                p_ux, p_uy;
    qte_pkg::angle_t              yaw_a, roll_a, pitch_a;
    qte_pkg::angle_t              yaw_dly_reg [PITCH_DELAY];
    qte_pkg::angle_t              roll_dly_reg [PITCH_DELAY];

    qte_pkg::angle_t              yaw_c_reg, pitch_c_reg, roll_c_reg;
    dprod_t                       yaw_p_reg, pitch_p_reg, roll_p_reg;
    logic signed [qte_pkg::OUT_W-1:0] yaw_deg, head_deg;
    qte_pkg::euler_t              euler_next, euler_reg;

    function automatic logic signed [qte_pkg::OUT_W-1:0] to_deg(dprod_t p);
        logic signed [DPW:0] t;
        logic signed [DPW:0] q;
        t = $signed({p[DPW-1], p}) + $signed((DPW+1)'(1) << 45);
        q = t >>> 46;
        if (q > qte_pkg::DEG_LIMIT)
        begin
            q = (DPW+1)'(qte_pkg::DEG_LIMIT);
        end
        else if (q < -qte_pkg::DEG_LIMIT)
        begin
            q = -(DPW+1)'(qte_pkg::DEG_LIMIT);
        end
        return q[qte_pkg::OUT_W-1:0];
    endfunction

    function automatic logic signed [qte_pkg::OUT_W-1:0] to_rad(qte_pkg::angle_t a);
        logic signed [qte_pkg::ANGLE_W:0] t;
        logic signed [qte_pkg::ANGLE_W:0] q;
        t = $signed({a[qte_pkg::ANGLE_W-1], a})
            + $signed((qte_pkg::ANGLE_W+1)'(1) << 16);
        q = t >>> 17;
        if (q > qte_pkg::RAD_LIMIT)
        begin
            q = (qte_pkg::ANGLE_W+1)'(qte_pkg::RAD_LIMIT);
        end
        else if (q < -qte_pkg::RAD_LIMIT)
        begin
            q = -(qte_pkg::ANGLE_W+1)'(qte_pkg::RAD_LIMIT);
        end
        return q[qte_pkg::OUT_W-1:0];
    endfunction

    assign en         = !(valid_reg[DEPTH-1] && euler_stall);
    assign quat_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            deg_mode_reg <= 1'b1;
        end
        else
        begin
            if (en)
            begin
                valid_reg <= {valid_reg[DEPTH-2:0], quat_valid};
            end
            if (cfg_write_enable)
            begin
                deg_mode_reg <= cfg_write_data;
            end
        end
    end

    always_comb
    begin
        yaw_y_next  = (qte_pkg::sum_t'(ij_reg) + qte_pkg::sum_t'(kr_reg)) <<< 1;
        yaw_x_next  = qte_pkg::sum_t'(ii_reg) - qte_pkg::sum_t'(jj_reg)
                    - qte_pkg::sum_t'(kk_reg) + qte_pkg::sum_t'(rr_reg);
        roll_y_next = (qte_pkg::sum_t'(jk_reg) + qte_pkg::sum_t'(ir_reg)) <<< 1;
        roll_x_next = qte_pkg::sum_t'(kk_reg) + qte_pkg::sum_t'(rr_reg)
                    - qte_pkg::sum_t'(ii_reg) - qte_pkg::sum_t'(jj_reg);
        pnum_next   = (qte_pkg::sum_t'(jr_reg) - qte_pkg::sum_t'(ik_reg)) <<< 1;
        pden_next   = qte_pkg::sum_t'(ii_reg) + qte_pkg::sum_t'(jj_reg)
                    + qte_pkg::sum_t'(kk_reg) + qte_pkg::sum_t'(rr_reg);
    end

    always_comb
    begin
        lead3 = qte_pkg::lead_one(qte_pkg::mag_t'(unsigned'(pden_reg)));
        if (lead3 > qte_pkg::LEAD_W'(qte_pkg::ROOT_SHIFT_MSB))
        begin
            shift3_next = lead3 - qte_pkg::LEAD_W'(qte_pkg::ROOT_SHIFT_MSB);
        end
        else
        begin
            shift3_next = '0;
        end
        un_sh = un3_reg >> shift3_reg;
        ud_sh = ud3_reg >> shift3_reg;
        ctx4_next.un   = un_sh[RW-1:0];
        ctx4_next.sat  = (un_sh >= ud_sh);
        ctx4_next.neg  = neg3_reg;
        ctx4_next.zero = zero3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= quat.q_real[qte_pkg::QUAT_WIDTH-1:qte_pkg::DROP_W];
            i_reg <= quat.q_i[qte_pkg::QUAT_WIDTH-1:qte_pkg::DROP_W];
            j_reg <= quat.q_j[qte_pkg::QUAT_WIDTH-1:qte_pkg::DROP_W];
            k_reg <= quat.q_k[qte_pkg::QUAT_WIDTH-1:qte_pkg::DROP_W];

            rr_reg <= r_reg * r_reg;
            ii_reg <= i_reg * i_reg;
            jj_reg <= j_reg * j_reg;
            kk_reg <= k_reg * k_reg;
            ij_reg <= i_reg * j_reg;
            kr_reg <= k_reg * r_reg;
            ik_reg <= i_reg * k_reg;
            jr_reg <= j_reg * r_reg;
            jk_reg <= j_reg * k_reg;
            ir_reg <= i_reg * r_reg;

            yaw_y_reg  <= yaw_y_next;
            yaw_x_reg  <= yaw_x_next;
            roll_y_reg <= roll_y_next;
            roll_x_reg <= roll_x_next;
            pnum_reg   <= pnum_next;
            pden_reg   <= pden_next;

            un3_reg    <= qte_pkg::magnitude(pnum_reg);
            ud3_reg    <= qte_pkg::mag_t'(unsigned'(pden_reg));
            neg3_reg   <= pnum_reg[qte_pkg::SUM_W-1];
            zero3_reg  <= (pnum_reg == '0) || (pden_reg == '0);
            shift3_reg <= shift3_next;

            ud4_reg  <= ud_sh[RW-1:0];
            ctx4_reg <= ctx4_next;

            udsq_reg <= qte_pkg::SQ_W'(ud4_reg) * qte_pkg::SQ_W'(ud4_reg);
            unsq_reg <= qte_pkg::SQ_W'(ctx4_reg.un) * qte_pkg::SQ_W'(ctx4_reg.un);
            ctx5_reg <= ctx4_reg;

            diff_reg <= udsq_reg - unsq_reg;
            ctx6_reg <= ctx5_reg;

            ctx_dly_reg[0] <= ctx6_reg;
            for (int n = 1; n < qte_pkg::SQRT_STEPS; n++)
            begin
                ctx_dly_reg[n] <= ctx_dly_reg[n-1];
            end

            yaw_dly_reg[0]  <= yaw_a;
            roll_dly_reg[0] <= roll_a;
            for (int n = 1; n < PITCH_DELAY; n++)
            begin
                yaw_dly_reg[n]  <= yaw_dly_reg[n-1];
                roll_dly_reg[n] <= roll_dly_reg[n-1];
            end
        end
    end

    assign sq_v[0] = diff_reg;
    assign sq_r[0] = '0;

    for (genvar g = 0; g < qte_pkg::SQRT_STEPS; g++)
    begin : g_sqrt
        qte_sqrt_cell #(
            .STEP (g)
        ) u_sqrt (
            .clk   (clk),
            .en    (en),
            .v_in  (sq_v[g]),
            .r_in  (sq_r[g]),
            .v_out (sq_v[g+1]),
            .r_out (sq_r[g+1])
        );
    end

    always_comb
    begin
        pctx = ctx_dly_reg[qte_pkg::SQRT_STEPS-1];
        if (pctx.sat)
        begin
            p_ux = '0;
            p_uy = qte_pkg::mag_t'(1);
        end
        else
        begin
            p_ux = qte_pkg::mag_t'(sq_r[qte_pkg::SQRT_STEPS][RW-1:0]);
            p_uy = qte_pkg::mag_t'(pctx.un);
        end
        if (pctx.zero)
        begin
            p_uy = '0;
        end
    end

    qte_atan_unit #(
        .STAGES (CORDIC_STAGES)
    ) u_yaw (
        .clk   (clk),
        .en    (en),
        .ux    (qte_pkg::magnitude(yaw_x_reg)),
        .uy    (qte_pkg::magnitude(yaw_y_reg)),
        .neg_x (yaw_x_reg[qte_pkg::SUM_W-1]),
        .neg_y (yaw_y_reg[qte_pkg::SUM_W-1]),
        .angle (yaw_a)
    );

    qte_atan_unit #(
        .STAGES (CORDIC_STAGES)
    ) u_roll (
        .clk   (clk),
        .en    (en),
        .ux    (qte_pkg::magnitude(roll_x_reg)),
        .uy    (qte_pkg::magnitude(roll_y_reg)),
        .neg_x (roll_x_reg[qte_pkg::SUM_W-1]),
        .neg_y (roll_y_reg[qte_pkg::SUM_W-1]),
        .angle (roll_a)
    );

    qte_atan_unit #(
        .STAGES (CORDIC_STAGES)
    ) u_pitch (
        .clk   (clk),
        .en    (en),
        .ux    (p_ux),
        .uy    (p_uy),
        .neg_x (1'b0),
        .neg_y (pctx.neg),
        .angle (pitch_a)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yaw_c_reg   <= yaw_dly_reg[PITCH_DELAY-1];
            roll_c_reg  <= roll_dly_reg[PITCH_DELAY-1];
            pitch_c_reg <= pitch_a;
            yaw_p_reg   <= yaw_dly_reg[PITCH_DELAY-1] * qte_pkg::DEG_K;
            roll_p_reg  <= roll_dly_reg[PITCH_DELAY-1] * qte_pkg::DEG_K;
            pitch_p_reg <= pitch_a * qte_pkg::DEG_K;
            euler_reg   <= euler_next;
        end
    end

    always_comb
    begin
        yaw_deg  = to_deg(yaw_p_reg);
        head_deg = yaw_deg;
        euler_next.heading_angle = unsigned'(head_deg)
            + (yaw_deg[qte_pkg::OUT_W-1] ? qte_pkg::OUT_W'(qte_pkg::FULL_TURN)
                                         : qte_pkg::OUT_W'(0));
        if (deg_mode_reg)
        begin
            euler_next.yaw_angle   = yaw_deg;
            euler_next.pitch_angle = to_deg(pitch_p_reg);
            euler_next.roll_angle  = to_deg(roll_p_reg);
        end
        else
        begin
            euler_next.yaw_angle   = to_rad(yaw_c_reg);
            euler_next.pitch_angle = to_rad(pitch_c_reg);
            euler_next.roll_angle  = to_rad(roll_c_reg);
        end
    end

    assign euler       = euler_reg;
    assign euler_valid = valid_reg[DEPTH-1];

endmodule

// ===== hdl/qte_checker.sv =====
// ----------------------------------------------------------------------------
// qte_checker: port-level checks for the Euler angle unit
// Watches both channels and the ranges of the result fields.
// ----------------------------------------------------------------------------
module qte_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            quat_valid,
    input logic            quat_stall,
    input logic            euler_valid,
    input logic            euler_stall,
    input qte_pkg::euler_t euler
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        euler_valid && euler_stall |=> euler_valid && $stable(euler))
        else $error("euler transfer dropped or changed under stall");

    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        quat_stall |-> euler_valid && euler_stall)
        else $error("quat stalled without a blocked result");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler_valid |-> euler.heading_angle < 16'(qte_pkg::FULL_TURN))
        else $error("heading outside one turn");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler_valid |->
            (euler.yaw_angle <= 16'sd25736) && (euler.yaw_angle >= -16'sd25736) &&
            (euler.roll_angle <= 16'sd25736) && (euler.roll_angle >= -16'sd25736) &&
            (euler.pitch_angle <= 16'sd12868) && (euler.pitch_angle >= -16'sd12868))
        else $error("angle outside its range");

endmodule

bind quaternion_to_euler_heading_unit qte_checker u_qte_checker (.*);
